// File: rtl/kse_pkg.sv
// ----------------------------------------------------------------------------
// kse_pkg
// Types and constants shared by the knob setpoint editor modules.
// ----------------------------------------------------------------------------
package kse_pkg;

    localparam int TIME_W  = 32;
    localparam int POS_W   = 32;
    localparam int SP_W    = 8;
    localparam int MS_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_HOLDOFF = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_LOW      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_HIGH     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HUM_LOW       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HUM_HIGH      = 3'd5;

    // Reset values
    localparam logic [MS_W-1:0] RST_PRESS_HOLDOFF = 16'd50;
    localparam logic [MS_W-1:0] RST_IDLE_TIMEOUT  = 16'd8000;
    localparam logic [SP_W-1:0] RST_TEMP_LOW      = 8'd50;
    localparam logic [SP_W-1:0] RST_TEMP_HIGH     = 8'd100;
    localparam logic [SP_W-1:0] RST_HUM_LOW       = 8'd20;
    localparam logic [SP_W-1:0] RST_HUM_HIGH      = 8'd90;
    localparam logic [SP_W-1:0] RST_TEMP_SP       = 8'd77;
    localparam logic [SP_W-1:0] RST_HUM_SP        = 8'd50;

    // Packed stream widths
    localparam int IN_TDATA_W  = 104;
    localparam int OUT_TDATA_W = 24;

    typedef struct packed {
        logic [MS_W-1:0] press_holdoff_ms;
        logic [MS_W-1:0] idle_timeout_ms;
        logic [SP_W-1:0] temp_low;
        logic [SP_W-1:0] temp_high;
        logic [SP_W-1:0] hum_low;
        logic [SP_W-1:0] hum_high;
    } t_cfg;

    typedef struct packed {
        logic [TIME_W-1:0]       now_ms;
        logic                    temp_pressed;
        logic                    hum_pressed;
        logic signed [POS_W-1:0] temp_position;
        logic signed [POS_W-1:0] hum_position;
    } t_in;

    typedef struct packed {
        logic [SP_W-1:0] temp_target;
        logic [SP_W-1:0] hum_target;
        logic            edit_active;
        logic            edit_is_temp;
        logic            save_pulse;
    } t_out;

endpackage

// File: rtl/kse_cfg_regs.sv
// ----------------------------------------------------------------------------
// kse_cfg_regs
// Configuration register file: hold-off, idle timeout and setpoint limits.
// ----------------------------------------------------------------------------
module kse_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_we,
    input  logic [kse_pkg::CFG_IDX_W-1:0]  i_index,
    input  logic [kse_pkg::CFG_DATA_W-1:0] i_data,
    output kse_pkg::t_cfg                  o_cfg
);
    import kse_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.press_holdoff_ms <= RST_PRESS_HOLDOFF;
            r_cfg.idle_timeout_ms  <= RST_IDLE_TIMEOUT;
            r_cfg.temp_low         <= RST_TEMP_LOW;
            r_cfg.temp_high        <= RST_TEMP_HIGH;
            r_cfg.hum_low          <= RST_HUM_LOW;
            r_cfg.hum_high         <= RST_HUM_HIGH;
        end else if (i_we) begin
            // drop writes to unknown indexes
            unique case (i_index)
                REG_PRESS_HOLDOFF: r_cfg.press_holdoff_ms <= i_data;
                REG_IDLE_TIMEOUT:  r_cfg.idle_timeout_ms  <= i_data;
                REG_TEMP_LOW:      r_cfg.temp_low         <= i_data[SP_W-1:0];
                REG_TEMP_HIGH:     r_cfg.temp_high        <= i_data[SP_W-1:0];
                REG_HUM_LOW:       r_cfg.hum_low          <= i_data[SP_W-1:0];
                REG_HUM_HIGH:      r_cfg.hum_high         <= i_data[SP_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/kse_core.sv
// ----------------------------------------------------------------------------
// kse_core
// Editor state and the per-sample update: press detection, mode selection,
// encoder step with clamp, idle timeout.
// ----------------------------------------------------------------------------
module kse_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_advance,
    input  kse_pkg::t_in   i_item,
    input  kse_pkg::t_cfg  i_cfg,
    output kse_pkg::t_out  o_result
);
    import kse_pkg::*;

    localparam logic signed [SP_W+1:0] UNIT_STEP = (SP_W+2)'(1);

    typedef struct packed {
        logic              editing;
        logic              editing_temp;
        logic [TIME_W-1:0] activity_time;
        logic [POS_W-1:0]  temp_last;
        logic [POS_W-1:0]  hum_last;
    } t_sel;

    logic [TIME_W-1:0] r_temp_press_time, n_temp_press_time;
    logic [TIME_W-1:0] r_hum_press_time,  n_hum_press_time;
    t_sel              r_sel, n_sel;
    logic [SP_W-1:0]   r_temp_sp, n_temp_sp;
    logic [SP_W-1:0]   r_hum_sp,  n_hum_sp;

    t_sel              sel_a;
    t_sel              sel_b;
    logic              temp_hit, hum_hit;
    logic [POS_W-1:0]  cur_pos, last_pos, pos_diff;
    logic              moved, step_down, save;
    logic [TIME_W-1:0] idle_time;

    function automatic t_sel select_param(input t_sel s, input logic want_temp,
                                          input logic [TIME_W-1:0] now,
                                          input logic [POS_W-1:0] tpos,
                                          input logic [POS_W-1:0] hpos);
        t_sel r;
        r = s;
        if (s.editing) begin
            if (s.editing_temp == want_temp) begin
                r.editing = 1'b0;
            end else begin
                r.editing_temp  = want_temp;
                r.activity_time = now;
                if (want_temp) begin
                    r.temp_last = tpos;
                end else begin
                    r.hum_last = hpos;
                end
            end
        end else begin
            r.editing       = 1'b1;
            r.editing_temp  = want_temp;
            r.activity_time = now;
            r.temp_last     = tpos;
            r.hum_last      = hpos;
        end
        return r;
    endfunction

    // Step by one unit, then clamp; low is tested first, so a value below low takes low even when the limits cross
    function automatic logic [SP_W-1:0] step_clamp(input logic [SP_W-1:0] old,
                                                   input logic down,
                                                   input logic [SP_W-1:0] lo,
                                                   input logic [SP_W-1:0] hi);
        logic signed [SP_W+1:0] v;
        v = down ? $signed({2'b00, old}) - UNIT_STEP : $signed({2'b00, old}) + UNIT_STEP;
        if (v < $signed({2'b00, lo})) begin
            return lo;
        end else if (v > $signed({2'b00, hi})) begin
            return hi;
        end
        return v[SP_W-1:0];
    endfunction

    always_comb begin
        n_temp_press_time = r_temp_press_time;
        n_hum_press_time  = r_hum_press_time;
        n_temp_sp         = r_temp_sp;
        n_hum_sp          = r_hum_sp;

        temp_hit = i_item.temp_pressed &&
                   ((i_item.now_ms - r_temp_press_time) >
                    {{(TIME_W-MS_W){1'b0}}, i_cfg.press_holdoff_ms});
        hum_hit  = i_item.hum_pressed &&
                   ((i_item.now_ms - r_hum_press_time) >
                    {{(TIME_W-MS_W){1'b0}}, i_cfg.press_holdoff_ms});

        sel_a = r_sel;
        if (temp_hit) begin
            n_temp_press_time = i_item.now_ms;
            sel_a = select_param(r_sel, 1'b1, i_item.now_ms,
                                 i_item.temp_position, i_item.hum_position);
        end
        sel_b = sel_a;
        if (hum_hit) begin
            n_hum_press_time = i_item.now_ms;
            sel_b = select_param(sel_a, 1'b0, i_item.now_ms,
                                 i_item.temp_position, i_item.hum_position);
        end

        cur_pos   = sel_b.editing_temp ? i_item.temp_position : i_item.hum_position;
        last_pos  = sel_b.editing_temp ? sel_b.temp_last : sel_b.hum_last;
        pos_diff  = cur_pos - last_pos;
        moved     = sel_b.editing && (cur_pos != last_pos);
        step_down = !pos_diff[POS_W-1];
        save      = moved;

        n_sel = sel_b;
        if (moved) begin
            if (sel_b.editing_temp) begin
                n_temp_sp       = step_clamp(r_temp_sp, step_down,
                                             i_cfg.temp_low, i_cfg.temp_high);
                n_sel.temp_last = cur_pos;
            end else begin
                n_hum_sp       = step_clamp(r_hum_sp, step_down,
                                            i_cfg.hum_low, i_cfg.hum_high);
                n_sel.hum_last = cur_pos;
            end
            n_sel.activity_time = i_item.now_ms;
        end

        idle_time = i_item.now_ms - n_sel.activity_time;
        if (sel_b.editing &&
            (idle_time > {{(TIME_W-MS_W){1'b0}}, i_cfg.idle_timeout_ms})) begin
            n_sel.editing = 1'b0;
        end

        o_result.temp_target  = n_temp_sp;
        o_result.hum_target   = n_hum_sp;
        o_result.edit_active  = n_sel.editing;
        o_result.edit_is_temp = n_sel.editing_temp;
        o_result.save_pulse   = save;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_press_time <= '0;
            r_hum_press_time  <= '0;
            r_sel             <= '0;
            r_temp_sp         <= RST_TEMP_SP;
            r_hum_sp          <= RST_HUM_SP;
        end else if (i_advance) begin
            r_temp_press_time <= n_temp_press_time;
            r_hum_press_time  <= n_hum_press_time;
            r_sel             <= n_sel;
            r_temp_sp         <= n_temp_sp;
            r_hum_sp          <= n_hum_sp;
        end
    end

endmodule

// File: rtl/kse_out_reg.sv
// ----------------------------------------------------------------------------
// kse_out_reg
// Result register on the output stream; refills in the cycle it drains.
// ----------------------------------------------------------------------------
module kse_out_reg (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  kse_pkg::t_out i_data,
    output logic          o_free,
    output logic          o_valid,
    input  logic          i_ready,
    output kse_pkg::t_out o_data
);
    import kse_pkg::*;

    logic r_valid;
    t_out r_data;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: rtl/knob_setpoint_editor.sv
// Path: input register, then result register; a sample waits in the input register
// while the result register is full and not draining.
// Throughput: one sample per cycle while the result side accepts; the whole update
// is one pass of logic between the input register and the result register.
// Reset: synchronous, active low; clears handshake state, loads the default
// limits and setpoints (77 degrees, 50 percent) and leaves edit mode.
// ----------------------------------------------------------------------------
// knob_setpoint_editor
// Two-knob temperature and humidity setpoint editor, one polling sample per
// stream transfer, one result per sample.
// ----------------------------------------------------------------------------
module knob_setpoint_editor (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // now_ms[31:0], temp_pressed[32], hum_pressed[33], temp_position[65:34],
    // hum_position[97:66], zero[103:98]
    input  logic [kse_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // temp_target[7:0], hum_target[15:8], edit_active[16], edit_is_temp[17],
    // save_pulse[18], zero[23:19]
    output logic [kse_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [kse_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [kse_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import kse_pkg::*;

    logic r_in_valid;
    t_in  r_in_item;
    t_in  in_item;
    t_cfg cfg;
    t_out core_result;
    t_out out_data;
    logic out_free;
    logic advance;

    assign in_item.now_ms        = s_axis_tdata[31:0];
    assign in_item.temp_pressed  = s_axis_tdata[32];
    assign in_item.hum_pressed   = s_axis_tdata[33];
    assign in_item.temp_position = s_axis_tdata[65:34];
    assign in_item.hum_position  = s_axis_tdata[97:66];

    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || advance;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_item <= in_item;
        end
    end

    kse_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_valid),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    kse_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in_item),
        .i_cfg     (cfg),
        .o_result  (core_result)
    );

    kse_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance),
        .i_data  (core_result),
        .o_free  (out_free),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_data  (out_data)
    );

    assign m_axis_tdata = {5'b00000, out_data.save_pulse, out_data.edit_is_temp,
                           out_data.edit_active, out_data.hum_target,
                           out_data.temp_target};

endmodule

// File: bench/knob_setpoint_editor_tb.sv
// ----------------------------------------------------------------------------
// knob_setpoint_editor_tb
// Self-checking bench for the two-knob setpoint editor. A directed table of
// polling samples covers press hold-off, parameter switching, rotation in both
// directions, encoder and time wrap, idle timeout and clamping. Random samples
// follow under several limit settings. Typed table rows are checked against their
// own values, every other result against a behavioral model of the editor in the bench.
// ----------------------------------------------------------------------------
module knob_setpoint_editor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kse_pkg::*;

    localparam int CLK_PERIOD      = 8;
    localparam int RESET_CYCLES    = 8;
    localparam int CYCLE_LIMIT     = 400000;
    localparam int PIPE_CYCLES     = 2;
    localparam int LONG_STALL      = 300;
    localparam int MAX_IDLE        = 16;
    localparam int REPORT_MAX      = 10;
    localparam int CLAMP_ROW       = 21;
    localparam int STALL_PHASE     = 5;
    localparam int ITEMS_PER_PHASE = 250;

    // indexes the block has no register for; writes to them must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic typed;
        t_out want;
    } t_hint;

    typedef struct packed {
        t_in  smp;
        logic typed;
        t_out want;
    } t_row;

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;

    // editor model state
    t_cfg              limits = '{RST_PRESS_HOLDOFF, RST_IDLE_TIMEOUT, RST_TEMP_LOW,
                                  RST_TEMP_HIGH, RST_HUM_LOW, RST_HUM_HIGH};
    logic [TIME_W-1:0] temp_press_t  = '0;
    logic [TIME_W-1:0] hum_press_t   = '0;
    logic [TIME_W-1:0] last_activity = '0;
    logic              editing       = 1'b0;
    logic              on_temp       = 1'b0;
    logic [POS_W-1:0]  temp_mark     = '0;
    logic [POS_W-1:0]  hum_mark      = '0;
    logic [SP_W-1:0]   temp_sp       = RST_TEMP_SP;
    logic [SP_W-1:0]   hum_sp        = RST_HUM_SP;

    t_out  pending_readouts[$];
    t_hint typed_q[$];
    int    fail_cnt = 0;
    int    cycle_cnt = 0;

    // random sample cursors
    logic [TIME_W-1:0] clock_ms;
    logic [POS_W-1:0]  temp_cursor;
    logic [POS_W-1:0]  hum_cursor;

    logic        tx_fast      = 1'b0;
    logic        rx_fast      = 1'b0;
    int unsigned rx_wait      = 0;
    int unsigned rx_hold      = 0;
    int unsigned stall_asks   = 0;
    int unsigned stall_served = 0;

    knob_setpoint_editor u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic void log_failure(input string what);
        if (fail_cnt < REPORT_MAX) begin
            $display("%0t ERROR %s", $realtime, what);
        end
        fail_cnt++;
    endfunction

    // counted press: toggle off the knob being edited, otherwise select it
    function automatic void pick_knob(input logic want_temp, input t_in s);
        if (editing) begin
            if (on_temp == want_temp) begin
                editing = 1'b0;
            end else begin
                on_temp       = want_temp;
                last_activity = s.now_ms;
                if (want_temp) begin
                    temp_mark = s.temp_position;
                end else begin
                    hum_mark = s.hum_position;
                end
            end
        end else begin
            editing       = 1'b1;
            on_temp       = want_temp;
            last_activity = s.now_ms;
            temp_mark     = s.temp_position;
            hum_mark      = s.hum_position;
        end
    endfunction

    // one unit step; low is tested first, so a value below low takes low even over an inverted high
    function automatic logic [SP_W-1:0] nudge(input logic [SP_W-1:0] sp, input logic down,
                                              input logic [SP_W-1:0] lo,
                                              input logic [SP_W-1:0] hi);
        int v;
        v = int'(sp) + (down ? -1 : 1);
        if (v < int'(lo)) begin
            return lo;
        end
        if (v > int'(hi)) begin
            return hi;
        end
        return SP_W'(v);
    endfunction

    function automatic t_out advance_editor(input t_in s);
        t_out             r;
        logic [POS_W-1:0] cur;
        logic [POS_W-1:0] delta;
        r.save_pulse = 1'b0;
        if (s.temp_pressed && (s.now_ms - temp_press_t) > limits.press_holdoff_ms) begin
            temp_press_t = s.now_ms;
            pick_knob(1'b1, s);
        end
        if (s.hum_pressed && (s.now_ms - hum_press_t) > limits.press_holdoff_ms) begin
            hum_press_t = s.now_ms;
            pick_knob(1'b0, s);
        end
        if (editing) begin
            cur   = on_temp ? s.temp_position : s.hum_position;
            delta = cur - (on_temp ? temp_mark : hum_mark);
            if (delta != '0) begin
                // positive change lowers the setpoint
                if (on_temp) begin
                    temp_sp   = nudge(temp_sp, !delta[POS_W-1], limits.temp_low,
                                      limits.temp_high);
                    temp_mark = cur;
                end else begin
                    hum_sp   = nudge(hum_sp, !delta[POS_W-1], limits.hum_low,
                                     limits.hum_high);
                    hum_mark = cur;
                end
                r.save_pulse  = 1'b1;
                last_activity = s.now_ms;
            end
            if ((s.now_ms - last_activity) > limits.idle_timeout_ms) begin
                editing = 1'b0;
            end
        end
        r.temp_target  = temp_sp;
        r.hum_target   = hum_sp;
        r.edit_active  = editing;
        r.edit_is_temp = on_temp;
        return r;
    endfunction

    always @(posedge i_clk) begin : scoreboard
        t_in   smp;
        t_out  got;
        t_out  want;
        t_hint hint;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_PRESS_HOLDOFF: limits.press_holdoff_ms = i_cfg_data;
                    REG_IDLE_TIMEOUT:  limits.idle_timeout_ms  = i_cfg_data;
                    REG_TEMP_LOW:      limits.temp_low  = i_cfg_data[SP_W-1:0];
                    REG_TEMP_HIGH:     limits.temp_high = i_cfg_data[SP_W-1:0];
                    REG_HUM_LOW:       limits.hum_low   = i_cfg_data[SP_W-1:0];
                    REG_HUM_HIGH:      limits.hum_high  = i_cfg_data[SP_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                smp.now_ms        = s_axis_tdata[31:0];
                smp.temp_pressed  = s_axis_tdata[32];
                smp.hum_pressed   = s_axis_tdata[33];
                smp.temp_position = s_axis_tdata[65:34];
                smp.hum_position  = s_axis_tdata[97:66];
                want = advance_editor(smp);
                hint = typed_q.pop_front();
                if (hint.typed) begin
                    want = hint.want;
                end
                pending_readouts.push_back(want);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.temp_target  = m_axis_tdata[7:0];
                got.hum_target   = m_axis_tdata[15:8];
                got.edit_active  = m_axis_tdata[16];
                got.edit_is_temp = m_axis_tdata[17];
                got.save_pulse   = m_axis_tdata[18];
                if (pending_readouts.size() == 0) begin
                    log_failure($sformatf("result with nothing expected: %h", m_axis_tdata));
                end else begin
                    want = pending_readouts.pop_front();
                    if (got.temp_target !== want.temp_target ||
                        got.hum_target !== want.hum_target ||
                        got.edit_active !== want.edit_active ||
                        got.edit_is_temp !== want.edit_is_temp ||
                        got.save_pulse !== want.save_pulse) begin
                        log_failure($sformatf(
                            "temp/hum/edit/is_temp/save exp %0d/%0d/%b/%b/%b got %0d/%0d/%b/%b/%b",
                            want.temp_target, want.hum_target, want.edit_active,
                            want.edit_is_temp, want.save_pulse, got.temp_target,
                            got.hum_target, got.edit_active, got.edit_is_temp,
                            got.save_pulse));
                    end
                end
            end
        end
    end

    // result side: per-result random wait, fast stretches, and a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (stall_asks != stall_served) begin
            stall_served = stall_asks;
            rx_hold      = LONG_STALL;
            rx_wait      = 0;
            m_axis_tready <= 1'b0;
        end else if (rx_hold != 0) begin
            rx_hold--;
            if (rx_hold == 0) begin
                m_axis_tready <= 1'b1;
            end
        end else if (m_axis_tready && m_axis_tvalid) begin
            if ($urandom_range(0, 39) == 0) begin
                rx_fast = !rx_fast;
            end
            rx_wait = rx_fast ? 0 : $urandom_range(0, MAX_IDLE);
            if (rx_wait != 0) begin
                m_axis_tready <= 1'b0;
            end
        end else if (rx_wait != 0) begin
            rx_wait--;
            if (rx_wait == 0) begin
                m_axis_tready <= 1'b1;
            end
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic push_sample(input t_in s, input logic typed, input t_out want);
        int unsigned gap;
        if ($urandom_range(0, 39) == 0) begin
            tx_fast = !tx_fast;
        end
        gap = tx_fast ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        typed_q.push_back('{typed, want});
        s_axis_tdata  <= {6'b0, s.hum_position, s.temp_position, s.hum_pressed,
                          s.temp_pressed, s.now_ms};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // drop valid and hold until every result is in, then let the pipe settle
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (typed_q.size() != 0 || pending_readouts.size() != 0);
        repeat (PIPE_CYCLES + 2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    // narrow registers get junk in the upper byte, which must be dropped
    task automatic write_all(input t_cfg c);
        write_reg(REG_PRESS_HOLDOFF, c.press_holdoff_ms);
        write_reg(REG_IDLE_TIMEOUT, c.idle_timeout_ms);
        write_reg(REG_TEMP_LOW, {8'($urandom), c.temp_low});
        write_reg(REG_TEMP_HIGH, {8'($urandom), c.temp_high});
        write_reg(REG_HUM_LOW, {8'($urandom), c.hum_low});
        write_reg(REG_HUM_HIGH, {8'($urandom), c.hum_high});
        write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, 16'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [POS_W-1:0] wander(input logic [POS_W-1:0] pos);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
            return pos + $urandom_range(0, 6) - 3;
        end
        if (pick < 80) begin
            return pos;
        end
        if (pick < 88) begin
            return pos + ($urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF);
        end
        if (pick < 95) begin
            return $urandom;
        end
        case ($urandom_range(0, 3))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    task automatic run_random(input int count);
        t_in         s;
        int unsigned pick;
        for (int k = 0; k < count; k++) begin
            // advance time mostly in small steps, sometimes around the hold-off or
            // timeout edges, sometimes anywhere including across the wrap
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                clock_ms += $urandom_range(0, 3);
            end else if (pick < 75) begin
                clock_ms += $urandom_range(1, 120);
            end else if (pick < 85) begin
                clock_ms += limits.press_holdoff_ms + $urandom_range(0, 3) - 1;
            end else if (pick < 93) begin
                clock_ms += limits.idle_timeout_ms + $urandom_range(0, 3) - 1;
            end else if (pick < 97) begin
                clock_ms += $urandom;
            end else begin
                clock_ms = $urandom_range(0, 1) ? $urandom : 32'hFFFF_FFF8 + $urandom_range(0, 7);
            end
            temp_cursor       = wander(temp_cursor);
            hum_cursor        = wander(hum_cursor);
            s.now_ms          = clock_ms;
            s.temp_pressed    = ($urandom_range(0, 9) == 0);
            s.hum_pressed     = ($urandom_range(0, 9) == 0);
            s.temp_position   = temp_cursor;
            s.hum_position    = hum_cursor;
            push_sample(s, 1'b0, '0);
        end
    endtask

    function automatic t_row plan_row(input logic [TIME_W-1:0] now, input logic tp,
                                      input logic hp, input logic [POS_W-1:0] tpos,
                                      input logic [POS_W-1:0] hpos, input logic typed,
                                      input logic [SP_W-1:0] tt, input logic [SP_W-1:0] ht,
                                      input logic ea, input logic et, input logic sv);
        t_row r;
        r.smp   = '{now, tp, hp, tpos, hpos};
        r.typed = typed;
        r.want  = '{tt, ht, ea, et, sv};
        return r;
    endfunction

    initial begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("knob_setpoint_editor verification failed");
        $finish;
    end

    initial begin : stimulus
        t_row plan[$];
        t_cfg phases[$];
        // reset limits: hold-off 50, timeout 8000, temp 50..100, hum 20..90
        plan.push_back(plan_row(0, 0, 0, 0, 0, 1, 77, 50, 0, 0, 0));
        // press exactly at the hold-off does not count
        plan.push_back(plan_row(50, 1, 0, 0, 0, 1, 77, 50, 0, 0, 0));
        plan.push_back(plan_row(51, 1, 0, 5, -3, 1, 77, 50, 1, 1, 0));
        plan.push_back(plan_row(52, 0, 0, 6, -3, 1, 76, 50, 1, 1, 1));
        plan.push_back(plan_row(53, 0, 0, 4, -3, 1, 77, 50, 1, 1, 1));
        // half-range jump reads as negative: step up
        plan.push_back(plan_row(54, 0, 0, 32'h8000_0004, -3, 1, 78, 50, 1, 1, 1));
        plan.push_back(plan_row(55, 0, 1, 32'h8000_0004, 100, 1, 78, 50, 1, 0, 0));
        plan.push_back(plan_row(56, 0, 0, 32'h8000_0004, 101, 1, 78, 49, 1, 0, 1));
        plan.push_back(plan_row(57, 0, 1, 32'h8000_0004, 101, 1, 78, 49, 1, 0, 0));
        // same knob again leaves edit mode
        plan.push_back(plan_row(106, 0, 1, 32'h8000_0004, 101, 1, 78, 49, 0, 0, 0));
        plan.push_back(plan_row(200, 1, 0, 32'h8000_0004, 101, 1, 78, 49, 1, 1, 0));
        // idle exactly at the timeout keeps edit mode, one more ms ends it
        plan.push_back(plan_row(8200, 0, 0, 32'h8000_0004, 101, 1, 78, 49, 1, 1, 0));
        plan.push_back(plan_row(8201, 0, 0, 32'h8000_0004, 101, 1, 78, 49, 0, 1, 0));
        // both buttons in one sample: temperature first, then switch to humidity
        plan.push_back(plan_row(8300, 1, 1, 32'h8000_0004, 101, 1, 78, 49, 1, 0, 0));
        plan.push_back(plan_row(8301, 0, 0, 32'h8000_0004, 32'h7FFF_FFFF, 1, 78, 48, 1, 0, 1));
        plan.push_back(plan_row(8302, 0, 0, 32'h8000_0004, 32'h8000_0000, 0, 0, 0, 0, 0, 0));
        plan.push_back(plan_row(32'hFFFF_FFFF, 0, 0, 32'h8000_0004, 32'h8000_0000,
                                0, 0, 0, 0, 0, 0));
        // time wrapped past zero
        plan.push_back(plan_row(5, 1, 0, 32'hFFFF_FFFF, 32'h8000_0000, 0, 0, 0, 0, 0, 0));
        plan.push_back(plan_row(6, 0, 0, 0, 32'h8000_0000, 0, 0, 0, 0, 0, 0));
        plan.push_back(plan_row(7, 0, 1, 0, 32'h8000_0000, 0, 0, 0, 0, 0, 0));
        plan.push_back(plan_row(8, 1, 1, 0, 32'h8000_0000, 0, 0, 0, 0, 0, 0));
        // from here temp_low 200 above temp_high 100: out-of-range value held, then clamped
        plan.push_back(plan_row(100, 1, 0, 0, 32'h8000_0000, 0, 0, 0, 0, 0, 0));
        plan.push_back(plan_row(101, 0, 0, 1, 32'h8000_0000, 0, 0, 0, 0, 0, 0));
        plan.push_back(plan_row(102, 0, 0, 0, 32'h8000_0000, 0, 0, 0, 0, 0, 0));
        plan.push_back(plan_row(103, 0, 0, 0, 32'h8000_0000, 0, 0, 0, 0, 0, 0));

        phases.push_back('{16'd0, 16'd0, 8'd0, 8'd0, 8'd0, 8'd0});
        phases.push_back('{16'd20, 16'd3000, 8'd0, 8'd255, 8'd0, 8'd255});
        phases.push_back('{16'hFFFF, 16'hFFFF, 8'd255, 8'd255, 8'd255, 8'd255});
        phases.push_back('{16'd1, 16'd500, 8'd0, 8'd255, 8'd0, 8'd255});
        phases.push_back('{16'd200, 16'd20, 8'd180, 8'd10, 8'd90, 8'd20});
        phases.push_back('{RST_PRESS_HOLDOFF, RST_IDLE_TIMEOUT, RST_TEMP_LOW,
                           RST_TEMP_HIGH, RST_HUM_LOW, RST_HUM_HIGH});
        repeat (2) begin
            phases.push_back('{16'($urandom_range(0, 300)), 16'($urandom_range(0, 4000)),
                               8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)});
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[k]) begin
            if (k == CLAMP_ROW) begin
                wait_drained();
                write_all('{RST_PRESS_HOLDOFF, RST_IDLE_TIMEOUT, 8'd200, 8'd100,
                            RST_HUM_LOW, RST_HUM_HIGH});
            end
            push_sample(plan[k].smp, plan[k].typed, plan[k].want);
        end

        clock_ms    = 103;
        temp_cursor = '0;
        hum_cursor  = 32'h8000_0000;
        foreach (phases[p]) begin
            wait_drained();
            write_all(phases[p]);
            if (p == STALL_PHASE) begin
                // keep offering samples while the result side is held off
                stall_asks++;
                run_random(ITEMS_PER_PHASE / 2);
                wait_drained();
                run_random(ITEMS_PER_PHASE / 2);
            end else begin
                run_random(ITEMS_PER_PHASE);
            end
        end

        wait_drained();
        if (pending_readouts.size() != 0) begin
            log_failure($sformatf("%0d results never arrived", pending_readouts.size()));
        end
        if (fail_cnt == 0) begin
            $display("knob_setpoint_editor verification clean");
        end else begin
            $display("knob_setpoint_editor verification failed");
        end
        $finish;
    end

endmodule

// File: filelist.f
rtl/kse_pkg.sv
rtl/kse_cfg_regs.sv
rtl/kse_core.sv
rtl/kse_out_reg.sv
rtl/knob_setpoint_editor.sv
bench/knob_setpoint_editor_tb.sv
